// File: sv/utf8_to_utf16_decoder_macros.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define UTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("utf8_to_utf16_decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("utf8_to_utf16_decoder assertion failed");

`else

`define UTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define UTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/utd_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
package utd_pkg;

  // Byte range limits of the UTF-8 lead and continuation bytes.
  localparam logic [7:0] Lead1Max = 8'h7F;
  localparam logic [7:0] ContMin  = 8'h80;
  localparam logic [7:0] ContMax  = 8'hBF;
  localparam logic [7:0] Lead2Max = 8'hDF;
  localparam logic [7:0] Lead3Max = 8'hEF;
  localparam logic [7:0] Lead4Max = 8'hF7;

  // Code point limits.
  localparam logic [20:0] SurrLow   = 21'h00D800;
  localparam logic [20:0] SurrHigh  = 21'h00DFFF;
  localparam logic [20:0] BmpMax    = 21'h00FFFF;
  localparam logic [20:0] CodeMax   = 21'h10FFFF;
  localparam logic [20:0] PairBase  = 21'h010000;

  // Top six bits of the high and low surrogate units.
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  typedef enum logic [1:0] {
    CMD_UNIT,
    CMD_PAIR,
    CMD_ERROR
  } cmd_kind_e;

  // One queued command: a single unit, a surrogate pair (value holds the
  // code point minus 0x10000) or the error result.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [19:0] value;
    logic        done;
  } cmd_t;

endpackage

// File: sv/utd_front.sv
// Front end: takes UTF-8 bytes, tracks the partial code point and issues commands.
`include "utf8_to_utf16_decoder_macros.svh"

module utd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    in_byte_i,
  input  logic          final_byte_i,
  input  logic          fifo_full_i,
  output logic          full_o,
  output logic          cmd_push_o,
  output utd_pkg::cmd_t cmd_o
);

  logic [20:0] pp_q, pp_d;
  logic [1:0]  pend_q, pend_d;
  logic        disc_q, disc_d;
  logic        accept;
  logic        cmd_valid;

  assign full_o = fifo_full_i;
  assign accept = push_i && !fifo_full_i;
  assign cmd_push_o = accept && cmd_valid;

  always_comb begin
    logic [20:0] nxt_pp;
    logic [1:0]  nxt_pend;
    logic [20:0] pair_val;
    logic        fail;

    pp_d       = pp_q;
    pend_d     = pend_q;
    disc_d     = disc_q;
    cmd_valid  = 1'b0;
    cmd_o.kind  = utd_pkg::CMD_UNIT;
    cmd_o.value = '0;
    cmd_o.done  = final_byte_i;
    nxt_pp     = pp_q;
    nxt_pend   = pend_q;
    fail       = 1'b0;
    pair_val   = pp_q - utd_pkg::PairBase;

    if (disc_q) begin
      if (final_byte_i) begin
        disc_d = 1'b0;
      end
    end else begin
      if (pend_q == 2'd0) begin
        if (in_byte_i inside {[8'h00 : utd_pkg::Lead1Max]}) begin
          nxt_pp = {13'd0, in_byte_i};
        end else if (in_byte_i inside {[utd_pkg::ContMin : utd_pkg::ContMax]}) begin
          fail = 1'b1;
        end else if (in_byte_i <= utd_pkg::Lead2Max) begin
          nxt_pp   = {16'd0, in_byte_i[4:0]};
          nxt_pend = 2'd1;
        end else if (in_byte_i <= utd_pkg::Lead3Max) begin
          nxt_pp   = {17'd0, in_byte_i[3:0]};
          nxt_pend = 2'd2;
        end else if (in_byte_i <= utd_pkg::Lead4Max) begin
          nxt_pp   = {18'd0, in_byte_i[2:0]};
          nxt_pend = 2'd3;
        end else begin
          fail = 1'b1;
        end
      end else if (in_byte_i inside {[utd_pkg::ContMin : utd_pkg::ContMax]}) begin
        nxt_pp   = {pp_q[14:0], in_byte_i[5:0]};
        nxt_pend = pend_q - 2'd1;
      end else begin
        fail = 1'b1;
      end

      pair_val = nxt_pp - utd_pkg::PairBase;

      if (!fail) begin
        if (nxt_pend != 2'd0) begin
          if (final_byte_i) begin
            // The string ended inside a multi-byte sequence.
            fail = 1'b1;
          end else begin
            pp_d   = nxt_pp;
            pend_d = nxt_pend;
          end
        end else begin
          pp_d   = '0;
          pend_d = 2'd0;
          if ((nxt_pp >= utd_pkg::SurrLow && nxt_pp <= utd_pkg::SurrHigh) ||
              nxt_pp > utd_pkg::CodeMax) begin
            fail = 1'b1;
          end else begin
            cmd_valid = 1'b1;
            if (nxt_pp <= utd_pkg::BmpMax) begin
              cmd_o.kind  = utd_pkg::CMD_UNIT;
              cmd_o.value = {4'd0, nxt_pp[15:0]};
            end else begin
              cmd_o.kind  = utd_pkg::CMD_PAIR;
              cmd_o.value = pair_val[19:0];
            end
          end
        end
      end

      if (fail) begin
        pp_d        = '0;
        pend_d      = 2'd0;
        disc_d      = !final_byte_i;
        cmd_valid   = 1'b1;
        cmd_o.kind  = utd_pkg::CMD_ERROR;
        cmd_o.value = '0;
        cmd_o.done  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      pend_q <= 2'd0;
      disc_q <= 1'b0;
    end else if (accept) begin
      pp_q   <= pp_d;
      pend_q <= pend_d;
      disc_q <= disc_d;
    end
  end

  // While bytes are dropped, no sequence is in progress.
  `UTD_ASSERT_IMPLY(disc_clears_seq, clk_i, rst_ni, disc_q, pend_q == 2'd0 && pp_q == '0)

endmodule

// File: sv/utd_fifo.sv
// Short command queue between the front end and the back end.
`include "utf8_to_utf16_decoder_macros.svh"

module utd_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utd_pkg::cmd_t data_i,
  input  logic          pop_i,
  output utd_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  utd_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    next_ptr = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `UTD_ASSERT_IMPLY(fifo_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `UTD_ASSERT_IMPLY(fifo_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

// File: sv/utd_back.sv
// Back end: turns queued commands into UTF-16 results in an output register.
`include "utf8_to_utf16_decoder_macros.svh"

module utd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  utd_pkg::cmd_t head_i,
  input  logic          fifo_empty_i,
  output logic          fifo_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [15:0]   code_unit_o,
  output logic          bad_sequence_o,
  output logic          string_done_o,
  output logic          run_end_o
);

  logic        out_valid_q, out_valid_d;
  logic        half_q, half_d;
  logic [15:0] unit_q, unit_d;
  logic        bad_q, bad_d;
  logic        done_q, done_d;
  logic        last_q, last_d;
  logic        load;

  assign empty_o        = !out_valid_q;
  assign code_unit_o    = unit_q;
  assign bad_sequence_o = bad_q;
  assign string_done_o  = done_q;
  assign run_end_o      = last_q;

  // The output register takes a new result when it is empty or being drained.
  assign load = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    half_d      = half_q;
    unit_d      = unit_q;
    bad_d       = bad_q;
    done_d      = done_q;
    last_d      = last_q;
    fifo_pop_o  = 1'b0;

    if (load) begin
      out_valid_d = !fifo_empty_i;
      if (!fifo_empty_i) begin
        if (half_q) begin
          // Second half of a pair; the entry leaves the queue now.
          unit_d     = {utd_pkg::LowSurrTag, head_i.value[9:0]};
          bad_d      = 1'b0;
          done_d     = head_i.done;
          last_d     = 1'b1;
          half_d     = 1'b0;
          fifo_pop_o = 1'b1;
        end else begin
          case (head_i.kind)
            utd_pkg::CMD_PAIR: begin
              unit_d = {utd_pkg::HighSurrTag, head_i.value[19:10]};
              bad_d  = 1'b0;
              done_d = 1'b0;
              last_d = 1'b0;
              half_d = 1'b1;
            end
            utd_pkg::CMD_ERROR: begin
              unit_d     = '0;
              bad_d      = 1'b1;
              done_d     = 1'b1;
              last_d     = 1'b1;
              fifo_pop_o = 1'b1;
            end
            default: begin
              unit_d     = head_i.value[15:0];
              bad_d      = 1'b0;
              done_d     = head_i.done;
              last_d     = 1'b1;
              fifo_pop_o = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    bad_q  <= bad_d;
    done_q <= done_d;
    last_q <= last_d;
  end

  // A pair entry stays at the head of the queue until its low half is loaded.
  `UTD_ASSERT_IMPLY(half_has_entry, clk_i, rst_ni, half_q, !fifo_empty_i)
  `UTD_ASSERT_NEXT(pair_splits, clk_i, rst_ni,
                   load && !half_q && !fifo_empty_i && head_i.kind == utd_pkg::CMD_PAIR,
                   half_q && out_valid_q && !last_q)

endmodule

// File: sv/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+-------------------------------------------------
//   bytes in | push / full         | in_byte_i[7:0], final_byte_i
//   units out| empty / pop         | code_unit_o[15:0], bad_sequence_o, string_done_o,
//            |                     | run_end_o
//
// One byte is taken per cycle while full is low; the front end decodes it in the cycle
// of its transfer. Results pass through the command queue to the output register and
// leave one per cycle while pop is high; a pair's entry stays until its low half loads.
// full follows the command queue (QueueDepth entries); empty follows the output register.
// Reset clears the code point, pending count, drop flag, queue and output register.
module utf8_to_utf16_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        bad_sequence_o,
  output logic        string_done_o,
  output logic        run_end_o
);

  utd_pkg::cmd_t cmd_in, cmd_head;
  logic          cmd_push, cmd_pop;
  logic          fifo_full, fifo_empty;

  utd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .fifo_full_i  (fifo_full),
    .full_o       (full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  utd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  utd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (cmd_head),
    .fifo_empty_i   (fifo_empty),
    .fifo_pop_o     (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .code_unit_o    (code_unit_o),
    .bad_sequence_o (bad_sequence_o),
    .string_done_o  (string_done_o),
    .run_end_o      (run_end_o)
  );

endmodule

// File: tb/tb_utf8_to_utf16_decoder.sv
// Self-checking testbench for the streaming UTF-8 to UTF-16 decoder.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       drain_first;
  } byte_item_t;

  typedef struct {
    logic [15:0] code_unit;
    logic        bad_sequence;
    logic        string_done;
    logic        run_end;
  } unit_result_t;

  localparam int HoldLen      = 120;
  localparam int HoldStartA   = 600;
  localparam int HoldStartB   = 2600;
  localparam int DrainCycles  = 20;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i    = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [15:0] code_unit_o;
  logic        bad_sequence_o;
  logic        string_done_o;
  logic        run_end_o;

  byte_item_t   pending_bytes[$];
  unit_result_t expected_units[$];

  // Decoder state as seen by the predictor.
  logic [20:0] acc_point;
  logic [1:0]  cont_left;
  logic        dropping;

  int mismatches;
  int tx_cycle;
  int tx_gap;
  int rx_cycle;
  int rx_stall;
  int rx_hold;
  bit tx_accepted;

  utf8_to_utf16_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .final_byte_i   (final_byte_i),
    .empty          (empty),
    .pop            (pop),
    .code_unit_o    (code_unit_o),
    .bad_sequence_o (bad_sequence_o),
    .string_done_o  (string_done_o),
    .run_end_o      (run_end_o)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, none at all during quiet stretches.
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic add_unit(input logic [15:0] unit, input logic bad, input logic done,
                          input logic last);
    unit_result_t r;
    r.code_unit    = unit;
    r.bad_sequence = bad;
    r.string_done  = done;
    r.run_end      = last;
    expected_units.insert(expected_units.size(), r);
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [20:0] cp;
    logic        err;
    err = 1'b0;
    cp  = '0;
    if (dropping) begin
      if (fin) dropping = 1'b0;
      return;
    end
    if (cont_left == 2'd0) begin
      if (b <= utd_pkg::Lead1Max) begin
        acc_point = {13'd0, b};
      end else if (b <= utd_pkg::ContMax) begin
        err = 1'b1;
      end else if (b <= utd_pkg::Lead2Max) begin
        acc_point = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b <= utd_pkg::Lead3Max) begin
        acc_point = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if (b <= utd_pkg::Lead4Max) begin
        acc_point = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        err = 1'b1;
      end
    end else if (b < utd_pkg::ContMin || b > utd_pkg::ContMax) begin
      err = 1'b1;
    end else begin
      acc_point = {acc_point[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
    end
    if (!err && cont_left != 2'd0) begin
      if (!fin) return;
      err = 1'b1;
    end
    if (!err) begin
      cp = acc_point;
      acc_point = '0;
      if ((cp >= utd_pkg::SurrLow && cp <= utd_pkg::SurrHigh) || cp > utd_pkg::CodeMax)
        err = 1'b1;
    end
    if (err) begin
      // One error result per string; the rest of the string is dropped.
      acc_point = '0;
      cont_left = 2'd0;
      dropping  = !fin;
      add_unit(16'h0000, 1'b1, 1'b1, 1'b1);
    end else if (cp <= utd_pkg::BmpMax) begin
      add_unit(cp[15:0], 1'b0, fin, 1'b1);
    end else begin
      cp = cp - utd_pkg::PairBase;
      add_unit({utd_pkg::HighSurrTag, cp[19:10]}, 1'b0, 1'b0, 1'b0);
      add_unit({utd_pkg::LowSurrTag, cp[9:0]}, 1'b0, fin, 1'b1);
    end
  endtask

  task automatic add_byte(input logic [7:0] value, input logic last, input logic drain);
    byte_item_t it;
    it.value       = value;
    it.last        = last;
    it.drain_first = drain;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  task automatic add_bytes(input logic [7:0] seq[$], input logic drain);
    for (int k = 0; k < seq.size(); k++) begin
      add_byte(seq[k], k == seq.size() - 1, drain && k == 0);
    end
  endtask

  // Mostly well-formed strings with random content; some get a corrupted,
  // missing or extra byte, and a few are plain noise.
  task automatic add_random_string(input logic drain);
    logic [7:0] seq[$];
    int n_chars;
    int n_cont;
    int r;
    seq = {};
    if ($urandom_range(0, 99) < 5) begin
      n_chars = $urandom_range(1, 6);
      for (int c = 0; c < n_chars; c++) seq.insert(seq.size(), 8'($urandom));
    end else begin
      n_chars = $urandom_range(1, 8);
      for (int c = 0; c < n_chars; c++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          seq.insert(seq.size(), 8'($urandom_range(8'h00, 8'h7F)));
          n_cont = 0;
        end else if (r < 50) begin
          seq.insert(seq.size(), 8'($urandom_range(8'hC0, 8'hDF)));
          n_cont = 1;
        end else if (r < 75) begin
          seq.insert(seq.size(), 8'($urandom_range(8'hE0, 8'hEF)));
          n_cont = 2;
        end else begin
          if ($urandom_range(0, 3) == 0)
            seq.insert(seq.size(), 8'($urandom_range(8'hF5, 8'hF7)));
          else
            seq.insert(seq.size(), 8'($urandom_range(8'hF0, 8'hF4)));
          n_cont = 3;
        end
        for (int k = 0; k < n_cont; k++)
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom);
      end else if (r < 14 && seq.size() > 1) begin
        seq.delete(seq.size() - 1);
      end else if (r < 18) begin
        seq.insert($urandom_range(0, seq.size() - 1), 8'($urandom));
      end
    end
    add_bytes(seq, drain);
  endtask

  // Sender: offers the head of the pending queue and holds it until the transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_cycle    = tx_cycle + 1;
      tx_accepted = push && !full;
      if (tx_accepted) begin
        void'(pending_bytes.pop_front());
        tx_gap = pick_gap(tx_cycle[9:8] == 2'b11);
      end
      if (push && !tx_accepted) begin
        push <= 1'b1;
      end else if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        push <= 1'b0;
      end else if (pending_bytes.size() != 0 && (!pending_bytes[0].drain_first ||
                   (!tx_accepted && expected_units.size() == 0))) begin
        push         <= 1'b1;
        in_byte_i    <= pending_bytes[0].value;
        final_byte_i <= pending_bytes[0].last;
        pending_bytes[0].drain_first = 1'b0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long holds that fill the block up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle == HoldStartA || rx_cycle == HoldStartB) rx_hold = HoldLen;
      if (pop && !empty) rx_stall = pick_gap(rx_cycle[9:8] == 2'b01);
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        pop <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall = rx_stall - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) predict_byte(in_byte_i, final_byte_i);
      if (pop && !empty) begin
        if (expected_units.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got unit=%h bad=%b done=%b end=%b",
                   $time, code_unit_o, bad_sequence_o, string_done_o, run_end_o);
        end else begin
          if (code_unit_o !== expected_units[0].code_unit ||
              bad_sequence_o !== expected_units[0].bad_sequence ||
              string_done_o !== expected_units[0].string_done ||
              run_end_o !== expected_units[0].run_end) begin
            mismatches++;
            $display("%0t: mismatch expected unit=%h bad=%b done=%b end=%b,",
                     $time, expected_units[0].code_unit, expected_units[0].bad_sequence,
                     expected_units[0].string_done, expected_units[0].run_end,
                     " got unit=%h bad=%b done=%b end=%b",
                     code_unit_o, bad_sequence_o, string_done_o, run_end_o);
          end
          void'(expected_units.pop_front());
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    mismatches = 0;
    tx_cycle   = 0;
    tx_gap     = 0;
    rx_cycle   = 0;
    rx_stall   = 0;
    rx_hold    = 0;
    acc_point  = '0;
    cont_left  = 2'd0;
    dropping   = 1'b0;

    // ASCII extremes, then the largest two- and three-byte values.
    add_bytes('{8'h00, 8'h7F}, 1'b0);
    add_bytes('{8'hDF, 8'hBF}, 1'b0);
    add_bytes('{8'hEF, 8'hBF, 8'hBF}, 1'b0);
    // A surrogate value mid-string, then a dropped final byte.
    add_byte(8'hED, 1'b0, 1'b0);
    add_byte(8'hA0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h41, 1'b1, 1'b0);
    // Highest legal code point as a pair, then a value above it.
    add_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
    add_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
    // Bad lead bytes: a final continuation byte, and a byte above the lead range.
    add_bytes('{8'h80}, 1'b0);
    add_bytes('{8'hF8, 8'hFF}, 1'b0);
    // A bad continuation byte, then a truncated sequence.
    add_bytes('{8'hC3, 8'h41}, 1'b0);
    add_bytes('{8'hE2, 8'h82}, 1'b0);

    // The first random string waits until the directed part has drained.
    add_random_string(1'b1);
    while (pending_bytes.size() < 1800) add_random_string($urandom_range(0, 99) == 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || expected_units.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
